// ===== hw/rtl/isl_pkg.sv =====
// Shared types and constants for the indexed shift list.
// Used by the channel interfaces, the controller, the entry cells and the checker.
package isl_pkg;

   localparam int OPCODE_W = 4;
   localparam int POS_W    = 5;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_RANGE = 3'd2,
      ST_FULL  = 3'd3,
      ST_NULL  = 3'd4
   } status_type;

   // what every cell does with its entry
   typedef enum logic [2:0] {
      CM_HOLD   = 3'd0,
      CM_INSERT = 3'd1,
      CM_DELETE = 3'd2,
      CM_SET    = 3'd3,
      CM_SWAP   = 3'd4
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type mode;
      logic          parity;       // which neighbour pairs swap this round
      logic          carry_load;   // snapshot entries into the read line
      logic          carry_shift;  // move the read line one place towards the head
   } cell_ctl_type;

endpackage

// ===== hw/rtl/isl_if.sv =====
// Request and response channel interfaces (valid/ready) for the indexed shift list.
// Depends on isl_pkg for field widths.
interface isl_req_if;
   logic                          valid;
   logic                          ready;
   logic [isl_pkg::OPCODE_W-1:0]  opcode;
   logic [isl_pkg::POS_W-1:0]     position;
   logic [isl_pkg::WORD_W-1:0]    value;

   modport source (output valid, opcode, position, value, input ready);
   modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface isl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [isl_pkg::WORD_W-1:0]    element;
   logic [isl_pkg::STATUS_W-1:0]  status;
   logic [isl_pkg::COUNT_W-1:0]   count;

   modport source (output valid, element, status, count, input ready);
   modport sink   (input valid, element, status, count, output ready);
endinterface

// ===== hw/rtl/isl_cell.sv =====
// One list entry and its read-line tap; of the cells it sees only its neighbours.
// Depends on isl_pkg for the cell control struct.
module isl_cell #(
   parameter int IDX   = 0,
   parameter int WIDTH = 32,
   parameter int IW    = 5
) (
   input  logic                  clock,
   input  isl_pkg::cell_ctl_type ctl,
   input  logic [IW-1:0]         at,
   input  logic [IW-1:0]         fill,
   input  logic [WIDTH-1:0]      word,
   input  logic [WIDTH-1:0]      left_data,
   input  logic [WIDTH-1:0]      right_data,
   input  logic [WIDTH-1:0]      right_carry,
   output logic [WIDTH-1:0]      data,
   output logic [WIDTH-1:0]      carry
);

   localparam logic [IW-1:0] IDX_V   = IW'(IDX);
   localparam logic [IW-1:0] IDX_P1  = IW'(IDX + 1);
   localparam logic          IDX_ODD = 1'(IDX % 2);

   logic [WIDTH-1:0] data_ff, data_in;
   logic [WIDTH-1:0] carry_ff, carry_in;

   always_comb begin
      data_in = data_ff;
      unique case (ctl.mode)
         isl_pkg::CM_HOLD: begin
         end
         isl_pkg::CM_INSERT: begin
            if (IDX_V == at) begin
               data_in = word;
            end else if (IDX_V > at && IDX_V <= fill) begin
               data_in = left_data;
            end
         end
         isl_pkg::CM_DELETE: begin
            if (IDX_V >= at && IDX_P1 < fill) begin
               data_in = right_data;
            end
         end
         isl_pkg::CM_SET: begin
            if (IDX_V == at) begin
               data_in = word;
            end
         end
         isl_pkg::CM_SWAP: begin
            // odd-even transposition with every pair exchanging
            if (IDX_ODD == ctl.parity && IDX_P1 < fill) begin
               data_in = right_data;
            end else if (IDX_ODD != ctl.parity && IDX_V != '0 && IDX_V < fill) begin
               data_in = left_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      priority if (ctl.carry_load) begin
         carry_in = data_ff;
      end else if (ctl.carry_shift) begin
         carry_in = right_carry;
      end else begin
         carry_in = carry_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      carry_ff <= carry_in;
   end

   assign data  = data_ff;
   assign carry = carry_ff;

endmodule

// ===== hw/rtl/isl_ctrl.sv =====
// Request decode, element count, sequencer and response register for the list.
// Depends on isl_pkg and on the isl_req_if / isl_rsp_if channel interfaces.
module isl_ctrl #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int IW    = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   isl_req_if.sink               req,
   isl_rsp_if.source             rsp,
   output isl_pkg::cell_ctl_type ctl,
   output logic [IW-1:0]         at,
   output logic [IW-1:0]         fill,
   output logic [WIDTH-1:0]      word,
   input  logic [WIDTH-1:0]      head_carry
);

   localparam int WW = isl_pkg::WORD_W;
   localparam int CW = isl_pkg::COUNT_W;
   localparam logic [IW-1:0] DEPTH_V = IW'(DEPTH);
   localparam logic [IW-1:0] ONE_V   = IW'(1);

   typedef enum logic [isl_pkg::OPCODE_W-1:0] {
      OP_APPEND    = 4'd0,
      OP_PREPEND   = 4'd1,
      OP_INSERT    = 4'd2,
      OP_DEL_FRONT = 4'd3,
      OP_DEL_REAR  = 4'd4,
      OP_DEL_AT    = 4'd5,
      OP_GET       = 4'd6,
      OP_SET       = 4'd7,
      OP_REVERSE   = 4'd8
   } opcode_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_REV  = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [IW-1:0]        fill_ff, fill_in;
   logic [IW-1:0]        cnt_ff, cnt_in;
   logic                 parity_ff, parity_in;
   isl_pkg::status_type  res_status_ff, res_status_in;
   logic                 res_read_ff, res_read_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0]        rsp_elem_ff, rsp_elem_in;
   isl_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [CW-1:0]        rsp_count_ff, rsp_count_in;

   opcode_type              op;
   logic [IW-1:0]           pos_x;
   logic [IW-1:0]           ins_at;
   logic                    stores;
   logic                    out_free;
   isl_pkg::status_type     d_status;
   logic [IW-1:0]           d_fill;
   isl_pkg::cell_mode_type  d_mode;
   logic [IW-1:0]           d_at;
   logic                    d_read;
   logic                    d_rev;

   assign word     = WIDTH'(req.value);
   assign op       = opcode_type'(req.opcode);
   assign pos_x    = IW'(req.position);
   assign stores   = (op == OP_APPEND) || (op == OP_PREPEND) || (op == OP_INSERT)
                     || (op == OP_SET);
   assign ins_at   = (op == OP_APPEND) ? fill_ff : ((op == OP_PREPEND) ? '0 : pos_x);
   assign out_free = !rsp_valid_ff || rsp.ready;

   // decode of the item on the request channel against the current count
   always_comb begin
      d_status = isl_pkg::ST_OK;
      d_fill   = fill_ff;
      d_mode   = isl_pkg::CM_HOLD;
      d_at     = '0;
      d_read   = 1'b0;
      d_rev    = 1'b0;
      if (stores && word == '0) begin
         d_status = isl_pkg::ST_NULL;
      end else begin
         unique case (op)
            OP_APPEND, OP_PREPEND, OP_INSERT: begin
               if (ins_at > fill_ff) begin
                  d_status = isl_pkg::ST_RANGE;
               end else if (fill_ff >= DEPTH_V) begin
                  d_status = isl_pkg::ST_FULL;
               end else begin
                  d_mode = isl_pkg::CM_INSERT;
                  d_at   = ins_at;
                  d_fill = fill_ff + ONE_V;
               end
            end
            OP_DEL_FRONT, OP_DEL_REAR, OP_DEL_AT, OP_GET, OP_SET, OP_REVERSE: begin
               priority if (fill_ff == '0) begin
                  d_status = isl_pkg::ST_EMPTY;
               end else if (op == OP_DEL_FRONT) begin
                  d_mode = isl_pkg::CM_DELETE;
                  d_read = 1'b1;
                  d_fill = fill_ff - ONE_V;
               end else if (op == OP_DEL_REAR) begin
                  d_mode = isl_pkg::CM_DELETE;
                  d_at   = fill_ff - ONE_V;
                  d_read = 1'b1;
                  d_fill = fill_ff - ONE_V;
               end else if (op == OP_REVERSE) begin
                  d_rev = (fill_ff > ONE_V);
               end else if (pos_x >= fill_ff) begin
                  d_status = isl_pkg::ST_RANGE;
               end else if (op == OP_DEL_AT) begin
                  d_mode = isl_pkg::CM_DELETE;
                  d_at   = pos_x;
                  d_read = 1'b1;
                  d_fill = fill_ff - ONE_V;
               end else if (op == OP_GET) begin
                  d_at   = pos_x;
                  d_read = 1'b1;
               end else begin
                  d_mode = isl_pkg::CM_SET;
                  d_at   = pos_x;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      cnt_in          = cnt_ff;
      parity_in       = parity_ff;
      res_status_in   = res_status_ff;
      res_read_in     = res_read_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_elem_in     = rsp_elem_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_count_in    = rsp_count_ff;
      ctl.mode        = isl_pkg::CM_HOLD;
      ctl.parity      = parity_ff;
      ctl.carry_load  = 1'b0;
      ctl.carry_shift = 1'b0;
      req.ready       = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               ctl.mode       = d_mode;
               ctl.carry_load = d_read;
               fill_in        = d_fill;
               res_status_in  = d_status;
               res_read_in    = d_read;
               if (d_rev) begin
                  state_in  = S_REV;
                  cnt_in    = fill_ff;
                  parity_in = 1'b0;
               end else if (d_read) begin
                  // the read line needs d_at moves to bring the entry to the head
                  state_in = (d_at == '0) ? S_FIN : S_SCAN;
                  cnt_in   = d_at;
               end else if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_elem_in   = '0;
                  rsp_status_in = d_status;
                  rsp_count_in  = d_fill[CW-1:0];
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_SCAN: begin
            ctl.carry_shift = 1'b1;
            cnt_in          = cnt_ff - ONE_V;
            if (cnt_ff == ONE_V) begin
               state_in = S_FIN;
            end
         end
         S_REV: begin
            ctl.mode  = isl_pkg::CM_SWAP;
            parity_in = !parity_ff;
            cnt_in    = cnt_ff - ONE_V;
            if (cnt_ff == ONE_V) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_elem_in   = res_read_ff ? WW'(head_carry) : '0;
               rsp_status_in = res_status_ff;
               rsp_count_in  = fill_ff[CW-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      parity_ff     <= parity_in;
      res_status_ff <= res_status_in;
      res_read_ff   <= res_read_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign at          = d_at;
   assign fill        = fill_ff;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.element = rsp_elem_ff;
   assign rsp.status  = rsp_status_ff;
   assign rsp.count   = rsp_count_ff;

endmodule

// ===== hw/rtl/indexed_shift_list.sv =====
// Append, prepend, insert, set, failed requests, unknown opcodes and reverse of under two
//   entries answer from idle, one item per cycle while the response register is free. Get
//   or delete at index k scan (read line moves one cell a cycle), then finish; reverse of n >= 2
//   entries swaps (one odd-even swap round a cycle), then finishes. Response register decouples ready.
// Reset (synchronous): count cleared, sequencer idle, no response; entries keep contents.
// Depends on isl_pkg, isl_if, isl_cell and isl_ctrl.
module indexed_shift_list #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   isl_req_if.sink   req_ch,
   isl_rsp_if.source rsp_ch
);

   localparam int FW = $clog2(DEPTH + 1);
   localparam int IW = (FW > isl_pkg::POS_W) ? FW : isl_pkg::POS_W;

   isl_pkg::cell_ctl_type ctl;
   logic [IW-1:0]         at;
   logic [IW-1:0]         fill;
   logic [WIDTH-1:0]      word;
   logic [WIDTH-1:0]      data_w   [DEPTH];
   logic [WIDTH-1:0]      carry_w  [DEPTH];
   logic [WIDTH-1:0]      left_w   [DEPTH];
   logic [WIDTH-1:0]      right_w  [DEPTH];
   logic [WIDTH-1:0]      rcarry_w [DEPTH];

   isl_ctrl #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH),
      .IW    (IW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .ctl        (ctl),
      .at         (at),
      .fill       (fill),
      .word       (word),
      .head_carry (carry_w[0])
   );

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_w[g] = '0;
      end else begin : g_mid
         assign left_w[g] = data_w[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign right_w[g]  = '0;
         assign rcarry_w[g] = '0;
      end else begin : g_body
         assign right_w[g]  = data_w[g+1];
         assign rcarry_w[g] = carry_w[g+1];
      end

      isl_cell #(
         .IDX   (g),
         .WIDTH (WIDTH),
         .IW    (IW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .at          (at),
         .fill        (fill),
         .word        (word),
         .left_data   (left_w[g]),
         .right_data  (right_w[g]),
         .right_carry (rcarry_w[g]),
         .data        (data_w[g]),
         .carry       (carry_w[g])
      );
   end

endmodule

// ===== hw/rtl/isl_checker.sv =====
// Port-level checks on the list's response channel, bound to the top level.
// Depends on isl_pkg for status codes and field widths.
module isl_checker #(
   parameter int DEPTH = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [isl_pkg::WORD_W-1:0]    rsp_element,
   input logic [isl_pkg::STATUS_W-1:0]  rsp_status,
   input logic [isl_pkg::COUNT_W-1:0]   rsp_count
);

   localparam logic [isl_pkg::COUNT_W-1:0] DEPTH_CNT = isl_pkg::COUNT_W'(DEPTH);

   // a failed request never carries an element
   a_fail_no_element: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != isl_pkg::ST_OK |-> rsp_element == '0)
      else $error("element returned with a failing status");

   // empty is only reported on an empty list
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == isl_pkg::ST_EMPTY |-> rsp_count == '0)
      else $error("empty status with nonzero count");

   // full is only reported when every slot is taken
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == isl_pkg::ST_FULL |-> rsp_count == DEPTH_CNT)
      else $error("full status with count below depth");

   // a stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element)
         && $stable(rsp_status) && $stable(rsp_count))
      else $error("response item changed while stalled");

endmodule

bind indexed_shift_list isl_checker #(
   .DEPTH (DEPTH)
) u_isl_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_element (rsp_ch.element),
   .rsp_status  (rsp_ch.status),
   .rsp_count   (rsp_ch.count)
);

// ===== tb/sv/indexed_shift_list_test.sv =====
// Self-checking test of the indexed shift list: directed corner items, then random traffic
// with idling on both sides and one long response stall. Depends on isl_pkg, isl_if and
// the indexed_shift_list RTL.
module indexed_shift_list_test;
   timeunit 1ns;
   timeprecision 1ps;

   import isl_pkg::*;

   localparam int LIST_DEPTH  = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_AFTER  = 200;   // results taken before the long response stall
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_REQS = 760;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND    = 4'd0,
      OP_PREPEND   = 4'd1,
      OP_INSERT    = 4'd2,
      OP_DEL_FRONT = 4'd3,
      OP_DEL_REAR  = 4'd4,
      OP_DEL_AT    = 4'd5,
      OP_GET       = 4'd6,
      OP_SET       = 4'd7,
      OP_REVERSE   = 4'd8,
      OP_UNUSED_LO = 4'd9,
      OP_UNUSED_HI = 4'd15
   } list_op_type;

   typedef enum int {GROW, SHRINK, MIXED} traffic_mode_type;

   typedef struct packed {
      logic [WORD_W-1:0]  element;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } list_result_type;

   // shadow copy of the list plus the queue of results still owed by the block
   class list_scoreboard;
      logic [WORD_W-1:0] slot [LIST_DEPTH];
      int                fill;
      list_result_type   awaited [$];
      int                errors;
      int                checked;
      int                status_hits [5];

      function new();
         fill    = 0;
         errors  = 0;
         checked = 0;
         foreach (status_hits[i]) status_hits[i] = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function logic [WORD_W-1:0] remove_at(int at);
         logic [WORD_W-1:0] taken;
         int i;
         taken = slot[at];
         for (i = at; i + 1 < fill; i++) slot[i] = slot[i + 1];
         fill--;
         return taken;
      endfunction

      function void note_request(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [WORD_W-1:0] val);
         list_result_type res;
         logic            stores;
         logic [WORD_W-1:0] t;
         int at, i, j;
         res.element = '0;
         res.status  = ST_OK;
         stores = (op == OP_APPEND) || (op == OP_PREPEND) || (op == OP_INSERT) ||
                  (op == OP_SET);
         if (stores && val == '0) begin
            res.status = ST_NULL;
         end else begin
            case (op)
               OP_APPEND, OP_PREPEND, OP_INSERT: begin
                  at = (op == OP_APPEND) ? fill : (op == OP_PREPEND) ? 0 : int'(pos);
                  if (at > fill) begin
                     res.status = ST_RANGE;
                  end else if (fill >= LIST_DEPTH) begin
                     res.status = ST_FULL;
                  end else begin
                     for (i = fill; i > at; i--) slot[i] = slot[i - 1];
                     slot[at] = val;
                     fill++;
                  end
               end
               OP_DEL_FRONT, OP_DEL_REAR, OP_DEL_AT, OP_GET, OP_SET, OP_REVERSE: begin
                  if (fill == 0) begin
                     res.status = ST_EMPTY;
                  end else if (op == OP_DEL_FRONT) begin
                     res.element = remove_at(0);
                  end else if (op == OP_DEL_REAR) begin
                     res.element = remove_at(fill - 1);
                  end else if (op == OP_REVERSE) begin
                     i = 0;
                     j = fill - 1;
                     while (i < j) begin
                        t       = slot[i];
                        slot[i] = slot[j];
                        slot[j] = t;
                        i++;
                        j--;
                     end
                  end else if (int'(pos) >= fill) begin
                     res.status = ST_RANGE;
                  end else if (op == OP_DEL_AT) begin
                     res.element = remove_at(int'(pos));
                  end else if (op == OP_GET) begin
                     res.element = slot[pos];
                  end else begin
                     slot[pos] = val;
                  end
               end
               default: ;   // unused opcodes leave everything as it is
            endcase
         end
         res.count = fill[COUNT_W-1:0];
         status_hits[res.status]++;
         awaited.push_back(res);
      endfunction

      function void compare_field(string name, logic [WORD_W-1:0] want,
                                  logic [WORD_W-1:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(logic [WORD_W-1:0] element, logic [STATUS_W-1:0] status,
                                 logic [COUNT_W-1:0] count);
         list_result_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, %s %0h status %0d count %0d",
                     $time, "actual element", element, status, count);
         end else begin
            want = awaited.pop_front();
            checked++;
            compare_field("element", want.element, element);
            compare_field("status", WORD_W'(want.status), WORD_W'(status));
            compare_field("count", WORD_W'(want.count), WORD_W'(count));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;      // when set, neither side idles
   int   cycles = 0;

   isl_req_if req_ch ();
   isl_rsp_if rsp_ch ();

   list_scoreboard sb = new();

   indexed_shift_list #(
      .DEPTH(LIST_DEPTH),
      .WIDTH(WORD_W)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic offer_request(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] val);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.opcode   = op;
      req_ch.position = pos;
      req_ch.value    = val;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(op, pos, val);
   endtask

   function automatic logic [OPCODE_W-1:0] pick_opcode(traffic_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return OPCODE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      case (mode)
         GROW:    return OPCODE_W'(r < 60 ? $urandom_range(OP_APPEND, OP_INSERT)
                                          : $urandom_range(OP_DEL_FRONT, OP_REVERSE));
         SHRINK:  return OPCODE_W'(r < 60 ? $urandom_range(OP_DEL_FRONT, OP_DEL_AT)
                                          : $urandom_range(OP_APPEND, OP_REVERSE));
         default: return OPCODE_W'($urandom_range(OP_APPEND, OP_REVERSE));
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 9);
      if (r < 8) return POS_W'($urandom_range(0, sb.fill));
      if (r == 8) return POS_W'(sb.fill);
      return POS_W'($urandom_range(0, 31));
   endfunction

   function automatic logic [WORD_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r == 2) return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
      return WORD_W'($urandom);
   endfunction

   // response side: random stalls, plus one long hold-off so the block backs up
   initial begin : drain
      int  stall;
      bit  held;
      held = 1'b0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 13);
         if (!held && sb.checked >= HOLD_AFTER) begin
            stall = HOLD_CYCLES;
            held  = 1'b1;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         sb.check_result(rsp_ch.element, rsp_ch.status, rsp_ch.count);
      end
   end

   initial begin : stimulus
      traffic_mode_type mode;
      int n;
      steady          = 1'b0;
      mode            = MIXED;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.opcode   = '0;
      req_ch.position = '0;
      req_ch.value    = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // every operation but prepend against the empty list
      offer_request(OP_GET, 5'd0, 32'h0);
      offer_request(OP_DEL_FRONT, 5'd0, 32'h0);
      offer_request(OP_DEL_REAR, 5'd0, 32'h0);
      offer_request(OP_DEL_AT, 5'd0, 32'h0);
      offer_request(OP_SET, 5'd0, 32'h5);
      offer_request(OP_REVERSE, 5'd0, 32'h0);
      offer_request(OP_INSERT, 5'd3, 32'h7);          // nonzero index into empty list
      offer_request(OP_APPEND, 5'd0, 32'h0);          // null word
      offer_request(OP_INSERT, 5'd5, 32'h0);          // null wins over range
      offer_request(OP_APPEND, 5'd0, 32'hFFFF_FFFF);
      offer_request(OP_PREPEND, 5'd0, 32'h1);
      offer_request(OP_INSERT, 5'd2, 32'h8000_0000);  // insert at count acts as append
      offer_request(OP_INSERT, 5'd1, 32'h1234_5678);
      offer_request(OP_GET, 5'd31, 32'h0);
      offer_request(OP_SET, 5'd0, 32'h0);
      offer_request(OP_SET, 5'd3, 32'hA5A5_A5A5);
      offer_request(OP_SET, 5'd4, 32'h1);             // index equal to count
      offer_request(OP_REVERSE, 5'd0, 32'h0);
      offer_request(OP_GET, 5'd0, 32'h0);
      offer_request(OP_DEL_AT, 5'd1, 32'h0);
      offer_request(OP_DEL_AT, 5'd3, 32'h0);
      offer_request(OP_UNUSED_HI, 5'd31, 32'hFFFF_FFFF);
      offer_request(OP_UNUSED_LO, 5'd0, 32'h1);
      offer_request(OP_INSERT, 5'd4, 32'h3);

      for (n = 0; n < RANDOM_REQS; n++) begin
         if (n % 40 == 0) begin
            mode   = traffic_mode_type'($urandom_range(0, 2));
            steady = ($urandom_range(0, 3) == 0);
         end
         offer_request(pick_opcode(mode), pick_position(), pick_value());
      end
      @(negedge clock);
      req_ch.valid = 1'b0;
      steady       = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Checked %0d results; status counts ok %0d, empty %0d, range %0d,",
               sb.checked, sb.status_hits[ST_OK], sb.status_hits[ST_EMPTY],
               sb.status_hits[ST_RANGE]);
      $display("full %0d, null %0d", sb.status_hits[ST_FULL], sb.status_hits[ST_NULL]);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/isl_pkg.sv
hw/rtl/isl_if.sv
hw/rtl/isl_cell.sv
hw/rtl/isl_ctrl.sv
hw/rtl/indexed_shift_list.sv
hw/rtl/isl_checker.sv
tb/sv/indexed_shift_list_test.sv
